/* sv/csr_sparse_matrix_store_top_defines.svh */
// Assertion macros for the sparse matrix store.
`ifndef CSR_SPARSE_MATRIX_STORE_TOP_DEFINES_SVH
`define CSR_SPARSE_MATRIX_STORE_TOP_DEFINES_SVH
`ifndef SYNTH
`define SMS_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("implication check failed");
`define SMS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");
`else
`define SMS_ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define SMS_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* sv/csr_sms_pkg.sv */
// Shared constants, codes and types of the sparse matrix store.
package csr_sms_pkg;
    localparam int MAX_ROWS_DEF       = 256;
    localparam int MAX_COLS_DEF       = 256;
    localparam int NNZ_MAX_DEF        = 1024;
    localparam int DENSE_COLS_MAX_DEF = 16;

    localparam logic [2:0] ACT_CLEAR = 3'd0;
    localparam logic [2:0] ACT_SET   = 3'd1;
    localparam logic [2:0] ACT_GET   = 3'd2;
    localparam logic [2:0] ACT_LOAD  = 3'd3;
    localparam logic [2:0] ACT_PROD  = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    localparam logic [1:0] CFG_ROWS  = 2'd0;
    localparam logic [1:0] CFG_COLS  = 2'd1;
    localparam logic [1:0] CFG_DCOLS = 2'd2;

    typedef struct packed {
        logic clr;
        logic mul;
        logic acc;
        logic rnd;
    } t_mac_ctl;
endpackage

/* sv/csr_sms_in_if.sv */
// Input item channel of the sparse matrix store.
interface csr_sms_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [7:0]         row;
    logic [7:0]         col;
    logic [3:0]         dense_col;
    logic signed [31:0] value;
    modport source (output valid, action, row, col, dense_col, value, input ready);
    modport sink   (input valid, action, row, col, dense_col, value, output ready);
endinterface

/* sv/csr_sms_out_if.sv */
// Result item channel of the sparse matrix store.
interface csr_sms_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    logic [1:0]         status;
    modport source (output valid, result, status, input ready);
    modport sink   (input valid, result, status, output ready);
endinterface

/* sv/csr_sparse_matrix_store_top.sv */
// Top level of the compressed-row sparse matrix store with dense product.
//
// Channel   Dir  Handshake     Payload
// i_in_ch   in   valid/ready   action, row, col, dense_col, value
// o_out_ch  out  valid/ready   result, status
// i_cfg_*   in   write enable  index, data
//
// One item at a time. Get and set search the row's entries in column order;
// an insert also moves the later stored entries up and bumps every later row start.
// Product walks the row entries through the multiply-accumulate unit.
// Clear sweeps the row starts. After reset a clearing pass over the row starts
// and the dense operand runs before the first item.
// A finished result waits in the output register while the next item is taken.
`include "csr_sparse_matrix_store_top_defines.svh"
module csr_sparse_matrix_store_top #(
    parameter int MAX_ROWS       = csr_sms_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS       = csr_sms_pkg::MAX_COLS_DEF,
    parameter int NNZ_MAX        = csr_sms_pkg::NNZ_MAX_DEF,
    parameter int DENSE_COLS_MAX = csr_sms_pkg::DENSE_COLS_MAX_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    csr_sms_in_if.sink    i_in_ch,
    csr_sms_out_if.source o_out_ch,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [8:0]    i_cfg_data
);
    localparam int RSW   = $clog2(NNZ_MAX + 1);
    localparam int NW    = (NNZ_MAX > 1) ? $clog2(NNZ_MAX) : 1;
    localparam int RAW   = $clog2(MAX_ROWS + 1);
    localparam int RKW   = $clog2(MAX_ROWS + 2);
    localparam int DN    = MAX_COLS * DENSE_COLS_MAX;
    localparam int DAW   = (DN > 1) ? $clog2(DN) : 1;
    localparam int SWEEP = (DN > MAX_ROWS + 1) ? DN : MAX_ROWS + 1;
    localparam int CW    = $clog2(SWEEP + 1);
    localparam int AW    = 64 + $clog2(NNZ_MAX + 1) + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_CHK, S_RB, S_RE, S_RN, S_RN2, S_SRCH, S_SCMP, S_MISS,
        S_GETV, S_GETW, S_SETW, S_SHR, S_SHW, S_INS, S_BRD, S_BWR, S_LD,
        S_PRD, S_PDR, S_PMUL, S_PACC, S_PRND, S_PSAT, S_DONE
    } t_state;

    function automatic logic [8:0] clamp_reg(input logic [8:0] v, input int maxv);
        logic [8:0] res;
        if (v == 9'd0) begin
            res = 9'd1;
        end else if (32'(v) > maxv) begin
            res = 9'(maxv);
        end else begin
            res = v;
        end
        return res;
    endfunction

    t_state       r_state;
    logic [8:0]   r_rows;
    logic [8:0]   r_cols;
    logic [4:0]   r_dcols;
    logic [2:0]   r_act;
    logic [7:0]   r_row;
    logic [7:0]   r_col;
    logic [3:0]   r_dc;
    logic [31:0]  r_val;
    logic [RSW-1:0] r_b, r_e, r_n, r_j, r_pos, r_k;
    logic [RKW-1:0] r_rk;
    logic [CW-1:0]  r_cnt;
    logic         r_clr_dense;
    logic [31:0]  r_pv;
    logic [31:0]  r_res;
    logic [1:0]   r_st;
    logic         r_out_valid;
    logic [31:0]  r_o_res;
    logic [1:0]   r_o_st;

    // memories
    logic [RSW-1:0] rs_mem [MAX_ROWS+1];
    logic [31:0]    vs_mem [NNZ_MAX];
    logic [7:0]     cs_mem [NNZ_MAX];
    logic [31:0]    ds_mem [DN];
    logic [RSW-1:0] rs_rdata;
    logic [31:0]    vs_rdata;
    logic [7:0]     cs_rdata;
    logic [31:0]    ds_rdata;

    logic           rs_re, rs_we, vc_re, vc_we, ds_re, ds_we;
    logic [RAW-1:0] rs_raddr, rs_waddr;
    logic [RSW-1:0] rs_wdata;
    logic [NW-1:0]  vc_raddr, vc_waddr;
    logic [31:0]    vs_wdata;
    logic [7:0]     cs_wdata;
    logic [DAW-1:0] ds_raddr, ds_waddr;
    logic [31:0]    ds_wdata;

    csr_sms_pkg::t_mac_ctl mac_ctl;
    logic signed [31:0]    mac_res;

    logic in_bad_rc, in_bad_ld, in_bad_pr;
    logic [RSW-1:0] e_clamped;

    assign in_bad_rc = ({1'b0, r_row} >= r_rows) || ({1'b0, r_col} >= r_cols);
    assign in_bad_ld = ({1'b0, r_row} >= r_cols) || ({1'b0, r_dc} >= r_dcols);
    assign in_bad_pr = ({1'b0, r_row} >= r_rows) || ({1'b0, r_dc} >= r_dcols);
    assign e_clamped = (rs_rdata > RSW'(NNZ_MAX)) ? RSW'(NNZ_MAX) : rs_rdata;

    assign i_in_ch.ready   = (r_state == S_IDLE);
    assign o_out_ch.valid  = r_out_valid;
    assign o_out_ch.result = r_o_res;
    assign o_out_ch.status = r_o_st;

    always_comb begin
        rs_re    = 1'b0;
        rs_raddr = '0;
        rs_we    = 1'b0;
        rs_waddr = '0;
        rs_wdata = '0;
        vc_re    = 1'b0;
        vc_raddr = '0;
        vc_we    = 1'b0;
        vc_waddr = '0;
        vs_wdata = r_val;
        cs_wdata = r_col;
        ds_re    = 1'b0;
        ds_raddr = '0;
        ds_we    = 1'b0;
        ds_waddr = '0;
        ds_wdata = '0;
        case (r_state)
            S_CLR: begin
                rs_we    = (r_cnt <= CW'(MAX_ROWS));
                rs_waddr = r_cnt[RAW-1:0];
                ds_we    = r_clr_dense && (r_cnt < CW'(DN));
                ds_waddr = r_cnt[DAW-1:0];
            end
            S_RB: begin
                rs_re    = 1'b1;
                rs_raddr = RAW'(r_row);
            end
            S_RE: begin
                rs_re    = 1'b1;
                rs_raddr = RAW'(32'(r_row) + 1);
            end
            S_RN: begin
                rs_re    = 1'b1;
                rs_raddr = RAW'(MAX_ROWS);
            end
            S_SRCH, S_PRD: begin
                vc_re    = 1'b1;
                vc_raddr = r_j[NW-1:0];
            end
            S_GETV: begin
                vc_re    = 1'b1;
                vc_raddr = r_pos[NW-1:0];
            end
            S_SETW: begin
                vc_we    = 1'b1;
                vc_waddr = r_pos[NW-1:0];
                cs_wdata = cs_rdata;
            end
            S_SHR: begin
                vc_re    = 1'b1;
                vc_raddr = NW'(r_k - 1'b1);
            end
            S_SHW: begin
                vc_we    = 1'b1;
                vc_waddr = r_k[NW-1:0];
                vs_wdata = vs_rdata;
                cs_wdata = cs_rdata;
            end
            S_INS: begin
                vc_we    = 1'b1;
                vc_waddr = r_pos[NW-1:0];
            end
            S_BRD: begin
                rs_re    = 1'b1;
                rs_raddr = r_rk[RAW-1:0];
            end
            S_BWR: begin
                rs_we    = 1'b1;
                rs_waddr = r_rk[RAW-1:0];
                rs_wdata = rs_rdata + 1'b1;
            end
            S_LD: begin
                ds_we    = 1'b1;
                ds_waddr = DAW'(32'(r_row) * DENSE_COLS_MAX + 32'(r_dc));
                ds_wdata = r_val;
            end
            S_PDR: begin
                ds_re    = 1'b1;
                ds_raddr = DAW'(32'(cs_rdata) * DENSE_COLS_MAX + 32'(r_dc));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rs_we) begin
            rs_mem[rs_waddr] <= rs_wdata;
        end
        if (rs_re) begin
            rs_rdata <= rs_mem[rs_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (vc_we) begin
            vs_mem[vc_waddr] <= vs_wdata;
            cs_mem[vc_waddr] <= cs_wdata;
        end
        if (vc_re) begin
            vs_rdata <= vs_mem[vc_raddr];
            cs_rdata <= cs_mem[vc_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ds_we) begin
            ds_mem[ds_waddr] <= ds_wdata;
        end
        if (ds_re) begin
            ds_rdata <= ds_mem[ds_raddr];
        end
    end

    always_comb begin
        mac_ctl.clr = (r_state == S_CHK);
        mac_ctl.mul = (r_state == S_PMUL);
        mac_ctl.acc = (r_state == S_PACC);
        mac_ctl.rnd = (r_state == S_PRND);
    end

    csr_sms_mac #(.AW(AW)) u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .i_a   (ds_rdata),
        .i_b   (r_pv),
        .o_res (mac_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= clamp_reg(9'd256, MAX_ROWS);
            r_cols  <= clamp_reg(9'd256, MAX_COLS);
            r_dcols <= 5'(clamp_reg(9'd16, DENSE_COLS_MAX));
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                csr_sms_pkg::CFG_ROWS:  r_rows  <= clamp_reg(i_cfg_data, MAX_ROWS);
                csr_sms_pkg::CFG_COLS:  r_cols  <= clamp_reg(i_cfg_data, MAX_COLS);
                csr_sms_pkg::CFG_DCOLS:
                    r_dcols <= 5'(clamp_reg({4'd0, i_cfg_data[4:0]}, DENSE_COLS_MAX));
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_cnt       <= '0;
            r_clr_dense <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            // the done state loads the output register itself
            if (r_out_valid && o_out_ch.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_ch.valid) begin
                        r_act   <= i_in_ch.action;
                        r_row   <= i_in_ch.row;
                        r_col   <= i_in_ch.col;
                        r_dc    <= i_in_ch.dense_col;
                        r_val   <= i_in_ch.value;
                        r_state <= S_CHK;
                    end
                end
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_clr_dense ? (r_cnt == CW'(SWEEP - 1)) : (r_cnt == CW'(MAX_ROWS))) begin
                        r_state <= r_clr_dense ? S_IDLE : S_DONE;
                    end
                end
                S_CHK: begin
                    r_res <= '0;
                    r_st  <= csr_sms_pkg::STAT_OK;
                    case (r_act)
                        csr_sms_pkg::ACT_CLEAR: begin
                            r_cnt       <= '0;
                            r_clr_dense <= 1'b0;
                            r_state     <= S_CLR;
                        end
                        csr_sms_pkg::ACT_SET, csr_sms_pkg::ACT_GET: begin
                            if (in_bad_rc) begin
                                r_st    <= csr_sms_pkg::STAT_RANGE;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_RB;
                            end
                        end
                        csr_sms_pkg::ACT_LOAD: begin
                            if (in_bad_ld) begin
                                r_st    <= csr_sms_pkg::STAT_RANGE;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_LD;
                            end
                        end
                        csr_sms_pkg::ACT_PROD: begin
                            if (in_bad_pr) begin
                                r_st    <= csr_sms_pkg::STAT_RANGE;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_RB;
                            end
                        end
                        default: begin
                            r_st    <= csr_sms_pkg::STAT_RANGE;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_RB: r_state <= S_RE;
                S_RE: begin
                    r_b     <= rs_rdata;
                    r_state <= S_RN;
                end
                S_RN: begin
                    r_e     <= e_clamped;
                    r_state <= S_RN2;
                end
                S_RN2: begin
                    r_n     <= rs_rdata;
                    r_j     <= r_b;
                    r_pos   <= r_e;
                    r_state <= (r_act == csr_sms_pkg::ACT_PROD) ? S_PRD : S_SRCH;
                end
                S_SRCH: begin
                    r_state <= (r_j < r_e) ? S_SCMP : S_MISS;
                end
                S_SCMP: begin
                    if (cs_rdata == r_col) begin
                        r_pos   <= r_j;
                        r_state <= (r_act == csr_sms_pkg::ACT_GET) ? S_GETV : S_SETW;
                    end else if (cs_rdata > r_col) begin
                        r_pos   <= r_j;
                        r_state <= S_MISS;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_SRCH;
                    end
                end
                S_MISS: begin
                    if (r_act == csr_sms_pkg::ACT_GET) begin
                        r_state <= S_DONE;
                    end else if (r_n >= RSW'(NNZ_MAX) || r_pos > r_n) begin
                        r_st    <= csr_sms_pkg::STAT_FULL;
                        r_state <= S_DONE;
                    end else begin
                        r_k     <= r_n;
                        r_state <= S_SHR;
                    end
                end
                S_GETV: r_state <= S_GETW;
                S_GETW: begin
                    r_res   <= vs_rdata;
                    r_state <= S_DONE;
                end
                S_SETW: r_state <= S_DONE;
                S_SHR: begin
                    r_state <= (r_k > r_pos) ? S_SHW : S_INS;
                end
                S_SHW: begin
                    r_k     <= r_k - 1'b1;
                    r_state <= S_SHR;
                end
                S_INS: begin
                    r_rk    <= RKW'(32'(r_row) + 1);
                    r_state <= S_BRD;
                end
                S_BRD: begin
                    r_state <= (r_rk <= RKW'(MAX_ROWS)) ? S_BWR : S_DONE;
                end
                S_BWR: begin
                    r_rk    <= r_rk + 1'b1;
                    r_state <= S_BRD;
                end
                S_LD: r_state <= S_DONE;
                S_PRD: begin
                    r_state <= (r_j < r_e) ? S_PDR : S_PRND;
                end
                S_PDR: begin
                    // skip entries whose column lies past the dense operand
                    if (32'(cs_rdata) >= MAX_COLS) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_PRD;
                    end else begin
                        r_pv    <= vs_rdata;
                        r_state <= S_PMUL;
                    end
                end
                S_PMUL: r_state <= S_PACC;
                S_PACC: begin
                    r_j     <= r_j + 1'b1;
                    r_state <= S_PRD;
                end
                S_PRND: r_state <= S_PSAT;
                S_PSAT: begin
                    r_res   <= mac_res;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_out_ch.ready) begin
                        r_out_valid <= 1'b1;
                        r_o_res     <= r_res;
                        r_o_st      <= r_st;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `SMS_ASSERT_IMPLY(a_fault_zero, i_clk, i_rst_n, o_out_ch.valid && o_out_ch.status != csr_sms_pkg::STAT_OK, o_out_ch.result == 32'd0)
    `SMS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_ch.valid && i_in_ch.ready, !i_in_ch.ready)
    `SMS_ASSERT_IMPLY(a_clear_blocks, i_clk, i_rst_n, r_state == S_CLR, !i_in_ch.ready && !ds_re)
endmodule

/* sv/csr_sms_mac.sv */
// Shared multiply-accumulate unit with rounding and Q16.16 saturation.
module csr_sms_mac #(
    parameter int AW = 77
) (
    input  logic                  i_clk,
    input  csr_sms_pkg::t_mac_ctl i_ctl,
    input  logic signed [31:0]    i_a,
    input  logic signed [31:0]    i_b,
    output logic signed [31:0]    o_res
);
    logic signed [63:0]   r_prod;
    logic signed [AW-1:0] r_acc;
    logic [AW-48:0]       hi;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= i_a * i_b;
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc) begin
            r_acc <= r_acc + {{(AW-64){r_prod[63]}}, r_prod};
        end else if (i_ctl.rnd) begin
            r_acc <= r_acc + AW'(32'h8000);
        end
    end

    // sum fits Q16.16 when bits from 47 up are all sign copies
    assign hi = r_acc[AW-1:47];
    always_comb begin
        if (hi == '0 || hi == '1) begin
            o_res = r_acc[47:16];
        end else if (r_acc[AW-1]) begin
            o_res = 32'sh8000_0000;
        end else begin
            o_res = 32'sh7FFF_FFFF;
        end
    end
endmodule

/* bench/csr_sms_store_checker.sv */
// Watches the sparse matrix store channels, predicts every result and compares.
`timescale 1ns / 1ps
module csr_sms_store_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    csr_sms_in_if  i_in_ch,
    csr_sms_out_if i_out_ch,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [8:0] i_cfg_data,
    output int     o_fail_cnt,
    output int     o_pending,
    output int     o_results
);
    typedef struct packed {
        logic [31:0] result;
        logic [1:0]  status;
    } t_answer;

    localparam int ROWS  = csr_sms_pkg::MAX_ROWS_DEF;
    localparam int COLS  = csr_sms_pkg::MAX_COLS_DEF;
    localparam int NNZ   = csr_sms_pkg::NNZ_MAX_DEF;
    localparam int DCOLS = csr_sms_pkg::DENSE_COLS_MAX_DEF;
    localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] SAT_LO = -128'sh8000_0000;

    logic [31:0] entry_val [NNZ];
    logic [7:0]  entry_col [NNZ];
    logic [10:0] row_first [ROWS+1];
    logic [31:0] dense_val [COLS*DCOLS];
    int          rows_lim, cols_lim, dcols_lim;
    t_answer     answers_due[$];

    assign o_pending = answers_due.size();

    function automatic int clamp_cfg(input logic [8:0] d, input int maxv);
        if (d < 1) return 1;
        if (d > maxv) return maxv;
        return int'(d);
    endfunction

    // Apply one item to the model state and return the answer it causes.
    function automatic t_answer apply_item(input logic [2:0] act, input logic [7:0] r,
                                           input logic [7:0] c, input logic [3:0] dc,
                                           input logic [31:0] v);
        t_answer a;
        int b, e, pos, n, j, k;
        bit found;
        logic signed [31:0] da, vb;
        logic signed [63:0] prod;
        logic signed [127:0] acc, q;
        a.result = '0;
        a.status = csr_sms_pkg::STAT_OK;
        case (act)
            csr_sms_pkg::ACT_CLEAR: begin
                for (k = 0; k <= ROWS; k++) row_first[k] = '0;
            end
            csr_sms_pkg::ACT_SET, csr_sms_pkg::ACT_GET: begin
                if (r >= rows_lim || c >= cols_lim) begin
                    a.status = csr_sms_pkg::STAT_RANGE;
                end else begin
                    b = int'(row_first[r]);
                    e = int'(row_first[r+1]);
                    pos = e;
                    found = 0;
                    if (e > NNZ) e = NNZ;
                    for (j = b; j < e; j++) begin
                        if (entry_col[j] == c) begin
                            found = 1;
                            pos = j;
                            break;
                        end
                        if (entry_col[j] > c) begin
                            pos = j;
                            break;
                        end
                    end
                    if (act == csr_sms_pkg::ACT_GET) begin
                        if (found) a.result = entry_val[pos];
                    end else if (found) begin
                        entry_val[pos] = v;
                    end else begin
                        n = int'(row_first[ROWS]);
                        if (n >= NNZ || pos > n) begin
                            a.status = csr_sms_pkg::STAT_FULL;
                        end else begin
                            for (j = n; j > pos; j--) begin
                                entry_val[j] = entry_val[j-1];
                                entry_col[j] = entry_col[j-1];
                            end
                            entry_val[pos] = v;
                            entry_col[pos] = c;
                            for (k = r + 1; k <= ROWS; k++) row_first[k]++;
                        end
                    end
                end
            end
            csr_sms_pkg::ACT_LOAD: begin
                if (r >= cols_lim || dc >= dcols_lim) a.status = csr_sms_pkg::STAT_RANGE;
                else dense_val[r*DCOLS + dc] = v;
            end
            csr_sms_pkg::ACT_PROD: begin
                if (r >= rows_lim || dc >= dcols_lim) begin
                    a.status = csr_sms_pkg::STAT_RANGE;
                end else begin
                    acc = '0;
                    for (j = int'(row_first[r]); j < int'(row_first[r+1]) && j < NNZ; j++)
                    begin
                        da = dense_val[entry_col[j]*DCOLS + dc];
                        vb = entry_val[j];
                        prod = da * vb;
                        acc += prod;
                    end
                    acc += 128'sd32768;
                    q = acc >>> 16;
                    if (q > SAT_HI) a.result = 32'h7FFF_FFFF;
                    else if (q < SAT_LO) a.result = 32'h8000_0000;
                    else a.result = q[31:0];
                end
            end
            default: a.status = csr_sms_pkg::STAT_RANGE;
        endcase
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        o_fail_cnt++;
    endtask

    initial begin
        o_fail_cnt = 0;
        o_results  = 0;
    end

    always @(posedge i_clk) begin
        t_answer want;
        t_answer fresh;
        if (!i_rst_n) begin
            for (int k = 0; k <= ROWS; k++) row_first[k] = '0;
            for (int k = 0; k < COLS*DCOLS; k++) dense_val[k] = '0;
            rows_lim  = ROWS;
            cols_lim  = COLS;
            dcols_lim = DCOLS;
            answers_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    csr_sms_pkg::CFG_ROWS:  rows_lim  = clamp_cfg(i_cfg_data, ROWS);
                    csr_sms_pkg::CFG_COLS:  cols_lim  = clamp_cfg(i_cfg_data, COLS);
                    csr_sms_pkg::CFG_DCOLS:
                        dcols_lim = clamp_cfg({4'd0, i_cfg_data[4:0]}, DCOLS);
                    default: ;
                endcase
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                o_results++;
                if (answers_due.size() == 0) begin
                    report_mismatch("unexpected result", '0, i_out_ch.result);
                end else begin
                    want = answers_due.pop_front();
                    if (i_out_ch.result !== want.result)
                        report_mismatch("result", want.result, i_out_ch.result);
                    if (i_out_ch.status !== want.status)
                        report_mismatch("status", want.status, i_out_ch.status);
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                fresh = apply_item(i_in_ch.action, i_in_ch.row, i_in_ch.col,
                                   i_in_ch.dense_col, i_in_ch.value);
                answers_due.insert(answers_due.size(), fresh);
            end
        end
    end
endmodule

/* bench/csr_sparse_matrix_store_top_tb.sv */
// Stimulus and verdict for the sparse matrix store.
`timescale 1ns / 1ps
module csr_sparse_matrix_store_top_tb;
    localparam int CYCLE_LIMIT = 20_000_000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [8:0] i_cfg_data;
    int         fail_cnt, pending, results;
    int         cycles, items_sent;
    int         idle_pct, stall_pct;
    int         rows_lim, cols_lim, dcols_lim;

    csr_sms_in_if  in_ch ();
    csr_sms_out_if out_ch ();

    csr_sparse_matrix_store_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch.sink),
        .o_out_ch   (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    csr_sms_store_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .i_out_ch   (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending),
        .o_results  (results)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(negedge i_clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 52; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 52; end
            default: begin idle_pct = 22; stall_pct = 22; end
        endcase
    endtask

    task automatic send_item(input logic [2:0] act, input logic [7:0] r, input logic [7:0] c,
                             input logic [3:0] dc, input logic [31:0] v);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.row       <= r;
        in_ch.col       <= c;
        in_ch.dense_col <= dc;
        in_ch.value     <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Hold the sender until every expected result is back, then let the block settle.
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] d);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic configure(input logic [8:0] r, input logic [8:0] c, input logic [8:0] dc);
        drain();
        write_reg(csr_sms_pkg::CFG_ROWS, r);
        write_reg(csr_sms_pkg::CFG_COLS, c);
        write_reg(csr_sms_pkg::CFG_DCOLS, dc);
        rows_lim  = (r < 1) ? 1 : (r > csr_sms_pkg::MAX_ROWS_DEF) ?
                    csr_sms_pkg::MAX_ROWS_DEF : r;
        cols_lim  = (c < 1) ? 1 : (c > csr_sms_pkg::MAX_COLS_DEF) ?
                    csr_sms_pkg::MAX_COLS_DEF : c;
        dcols_lim = (dc[4:0] < 1) ? 1 : (dc[4:0] > csr_sms_pkg::DENSE_COLS_MAX_DEF) ?
                    csr_sms_pkg::DENSE_COLS_MAX_DEF : dc[4:0];
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(1, 3) << 16;
            2: return -($urandom_range(1, 3) << 16);
            default: return $urandom_range(255) << 12;
        endcase
    endfunction

    // Mostly in-range indexes, now and then anything the field holds.
    function automatic logic [7:0] pick_index(input int lim);
        if ($urandom_range(9) == 0) return 8'($urandom_range(255));
        return 8'($urandom_range(lim - 1));
    endfunction

    task automatic random_items(input int count);
        logic [2:0] act;
        int roll;
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0) set_idling($urandom_range(3));
            roll = $urandom_range(99);
            if (roll < 35)      act = csr_sms_pkg::ACT_SET;
            else if (roll < 58) act = csr_sms_pkg::ACT_GET;
            else if (roll < 75) act = csr_sms_pkg::ACT_LOAD;
            else if (roll < 93) act = csr_sms_pkg::ACT_PROD;
            else if (roll < 96) act = csr_sms_pkg::ACT_CLEAR;
            else                act = 3'($urandom_range(5, 7));
            if (act == csr_sms_pkg::ACT_LOAD)
                send_item(act, pick_index(cols_lim), 8'($urandom_range(255)),
                          4'(pick_index(dcols_lim)), pick_value());
            else
                send_item(act, pick_index(rows_lim), pick_index(cols_lim),
                          4'(pick_index(dcols_lim)), pick_value());
        end
    endtask

    initial begin
        logic [7:0] kept_col;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = csr_sms_pkg::CFG_ROWS;
        i_cfg_data     = '0;
        in_ch.valid     = 1'b0;
        in_ch.action    = csr_sms_pkg::ACT_CLEAR;
        in_ch.row       = '0;
        in_ch.col       = '0;
        in_ch.dense_col = '0;
        in_ch.value     = '0;
        out_ch.ready    = 1'b1;
        items_sent = 0;
        rows_lim   = csr_sms_pkg::MAX_ROWS_DEF;
        cols_lim   = csr_sms_pkg::MAX_COLS_DEF;
        dcols_lim  = csr_sms_pkg::DENSE_COLS_MAX_DEF;
        set_idling(0);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty reads, overwrite, extremes, saturation, bad actions, clear.
        send_item(csr_sms_pkg::ACT_GET,  0, 0, 0, 0);
        send_item(csr_sms_pkg::ACT_SET,  0, 5, 0, 32'h7FFF_FFFF);
        send_item(csr_sms_pkg::ACT_SET,  0, 3, 0, 32'hFFFF_FFFF);
        send_item(csr_sms_pkg::ACT_SET,  0, 5, 0, 32'h0001_0000);
        send_item(csr_sms_pkg::ACT_GET,  0, 5, 0, 0);
        send_item(csr_sms_pkg::ACT_GET,  0, 4, 0, 0);
        send_item(csr_sms_pkg::ACT_SET,  255, 255, 0, 32'h8000_0000);
        send_item(csr_sms_pkg::ACT_GET,  255, 255, 0, 0);
        send_item(csr_sms_pkg::ACT_SET,  2, 5, 0, 32'h7FFF_FFFF);
        send_item(csr_sms_pkg::ACT_SET,  3, 3, 0, 32'h7FFF_FFFF);
        send_item(csr_sms_pkg::ACT_LOAD, 5, 0, 0, 32'h7FFF_FFFF);
        send_item(csr_sms_pkg::ACT_LOAD, 3, 0, 0, 32'h8000_0000);
        send_item(csr_sms_pkg::ACT_LOAD, 255, 0, 15, 32'h0002_8000);
        send_item(csr_sms_pkg::ACT_PROD, 0, 0, 0, 0);
        send_item(csr_sms_pkg::ACT_PROD, 2, 0, 0, 0);
        send_item(csr_sms_pkg::ACT_PROD, 3, 0, 0, 0);
        send_item(csr_sms_pkg::ACT_PROD, 255, 0, 15, 0);
        send_item(csr_sms_pkg::ACT_PROD, 1, 0, 0, 0);
        send_item(3'd5, 0, 0, 0, 0);
        send_item(3'd6, 255, 255, 15, 32'hFFFF_FFFF);
        send_item(3'd7, 0, 0, 0, 0);
        send_item(csr_sms_pkg::ACT_CLEAR, 0, 0, 0, 0);
        send_item(csr_sms_pkg::ACT_GET,  0, 5, 0, 0);
        send_item(csr_sms_pkg::ACT_PROD, 0, 0, 0, 0);

        // Fill the store row by row with ascending columns, then overflow it.
        for (int i = 0; i < csr_sms_pkg::NNZ_MAX_DEF; i++) begin
            if (i % 250 == 0) set_idling(i / 250);
            kept_col = 8'((i % 4) * 64 + $urandom_range(1, 63));
            send_item(csr_sms_pkg::ACT_SET, 8'(i / 4), kept_col, 0, pick_value());
            if (i % 64 == 0)
                send_item(csr_sms_pkg::ACT_LOAD, kept_col, 0, 4'($urandom_range(15)),
                          pick_value());
        end
        send_item(csr_sms_pkg::ACT_SET,  0, 0, 0, 32'h1234_5678);
        send_item(csr_sms_pkg::ACT_SET,  255, kept_col, 0, 32'h0BAD_0001);
        send_item(csr_sms_pkg::ACT_GET,  255, kept_col, 0, 0);
        send_item(csr_sms_pkg::ACT_PROD, 255, 0, 0, 0);
        send_item(csr_sms_pkg::ACT_PROD, 10, 0, 3, 0);
        send_item(csr_sms_pkg::ACT_CLEAR, 0, 0, 0, 0);

        configure(9'd256, 9'd256, 9'd16);
        random_items(60);
        configure(9'd8, 9'd16, 9'd4);
        random_items(70);
        configure(9'd1, 9'd1, 9'd1);
        random_items(30);
        configure(9'd0, 9'd0, 9'd0);
        random_items(20);
        configure(9'd511, 9'd511, 9'd31);
        random_items(50);
        configure(9'd3, 9'd200, 9'd9);
        random_items(50);

        drain();
        $display("sent %0d items and checked %0d results over %0d cycles",
                 items_sent, results, cycles);
        $display("covered overwrite, insert, full store, saturation, range faults, clamped regs");
        if (fail_cnt == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+sv
sv/csr_sms_pkg.sv
sv/csr_sms_in_if.sv
sv/csr_sms_out_if.sv
sv/csr_sms_mac.sv
sv/csr_sparse_matrix_store_top.sv
bench/csr_sms_store_checker.sv
bench/csr_sparse_matrix_store_top_tb.sv
